/* design/tbba_pkg.sv */
// Shared types, widths and codes for the token-budget batch admission block.
package tbba_pkg;

    // Sizing
    localparam int MAX_BATCH  = 256;
    localparam int TOKEN_BITS = 16;
    localparam int CNT_W      = 9;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Item actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_OFFER = 1'b1;

    // Request phases
    localparam logic [1:0] PH_WAITING = 2'd0;
    localparam logic [1:0] PH_PREFILL = 2'd1;
    localparam logic [1:0] PH_DECODE  = 2'd2;
    localparam logic [1:0] PH_OTHER   = 2'd3;

    // Register indexes (word address)
    localparam logic [1:0] REG_BATCH_LIMIT  = 2'd0;
    localparam logic [1:0] REG_TOKEN_LIMIT  = 2'd1;
    localparam logic [1:0] REG_SPLIT_ENABLE = 2'd2;
    localparam logic [1:0] REG_CHUNK_SIZE   = 2'd3;

    // Reset values of the registers
    localparam logic [CNT_W-1:0]      BATCH_LIMIT_RST = CNT_W'(16);
    localparam logic [TOKEN_BITS-1:0] TOKEN_LIMIT_RST = TOKEN_BITS'(2048);
    localparam logic [TOKEN_BITS-1:0] CHUNK_SIZE_RST  = TOKEN_BITS'(512);

    typedef struct packed {
        logic [CNT_W-1:0]      batch_limit;
        logic [TOKEN_BITS-1:0] token_limit;
        logic                  split_enable;
        logic [TOKEN_BITS-1:0] chunk_size;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0]      count;
        logic [TOKEN_BITS-1:0] tokens;
        logic [CNT_W-1:0]      prefill;
        logic [CNT_W-1:0]      decode;
        logic                  closed;
    } batch_t;

    typedef struct packed {
        logic       admitted;
        logic       requeue;
        logic [1:0] new_phase;
    } decide_t;

endpackage

/* design/tbba_admit.sv */
// Admission decision: token cost of one request and the updated batch totals.
module tbba_admit import tbba_pkg::*;
(
    input  cfg_t                  cfg,
    input  batch_t                batch,
    input  logic                  action,
    input  logic                  from_pending,
    input  logic [1:0]            phase,
    input  logic [TOKEN_BITS-1:0] prompt_tokens,
    input  logic [TOKEN_BITS-1:0] done_tokens,
    output batch_t                batch_next,
    output decide_t               decide
);

    logic [TOKEN_BITS-1:0] remain;
    logic [TOKEN_BITS-1:0] chunked;
    logic [TOKEN_BITS-1:0] cost;
    logic [TOKEN_BITS:0]   sum;
    logic                  room;
    logic                  fits;

    // Remaining prompt tokens, clamped at zero, optionally capped at a chunk
    assign remain  = (prompt_tokens > done_tokens) ? (prompt_tokens - done_tokens) : '0;
    assign chunked = (cfg.split_enable && (remain > cfg.chunk_size)) ? cfg.chunk_size : remain;

    always_comb
    begin
        case (phase)
            PH_WAITING, PH_PREFILL: cost = chunked;
            PH_DECODE:              cost = TOKEN_BITS'(1);
            default:                cost = '0;
        endcase
    end

    // Count limit is further capped by the batch array size
    assign room = (32'(batch.count) < 32'(cfg.batch_limit)) && (32'(batch.count) < MAX_BATCH);
    assign sum  = {1'b0, batch.tokens} + {1'b0, cost};
    assign fits = room && (sum <= {1'b0, cfg.token_limit});

    // Batch update
    always_comb
    begin
        batch_next         = batch;
        decide.admitted    = 1'b0;
        decide.requeue     = 1'b0;
        decide.new_phase   = phase;
        if (action == ACT_START)
        begin
            batch_next = '0;
        end
        else if (!(from_pending && batch.closed))
        begin
            if (fits)
            begin
                decide.admitted   = 1'b1;
                batch_next.count  = batch.count + CNT_W'(1);
                batch_next.tokens = sum[TOKEN_BITS-1:0];
                if ((phase == PH_PREFILL) || ((phase == PH_WAITING) && from_pending))
                begin
                    batch_next.prefill = batch.prefill + CNT_W'(1);
                    decide.new_phase   = PH_PREFILL;
                end
                else if (phase == PH_DECODE)
                begin
                    batch_next.decode = batch.decode + CNT_W'(1);
                end
            end
            else if (from_pending)
            begin
                decide.requeue    = 1'b1;
                batch_next.closed = 1'b1;
            end
        end
    end

endmodule

/* design/token_budget_batch_admission.sv */
// Top level of the token-budget batch admission block: registers, state and result stage.
//
// Each item (a start or an offered request) is decided in the cycle it is accepted and its
// result appears in the output register on the next cycle, so the block takes one item per
// clock. The only thing that holds input back is the single result register: a new item is
// taken whenever that register is empty or its result is being taken in the same cycle.
// Batch totals live in flip-flops, and the cost, limit compare and accumulate for one
// request form one short combinational step. Configuration goes through an APB-style port
// with registers at byte offsets 0x0 batch_limit, 0x4 token_limit, 0x8 split_enable and
// 0xC chunk_size; write them only while no item is in flight.
module token_budget_batch_admission import tbba_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready,
    // Input channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic                  from_pending,
    input  logic [1:0]            phase,
    input  logic [TOKEN_BITS-1:0] prompt_tokens,
    input  logic [TOKEN_BITS-1:0] done_tokens,
    input  logic [TOKEN_BITS-1:0] request_tag,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOKEN_BITS-1:0] tag_out,
    output logic                  admitted,
    output logic                  requeue,
    output logic [1:0]            new_phase,
    output logic                  pending_closed,
    output logic [CNT_W-1:0]      batch_count,
    output logic [TOKEN_BITS-1:0] batch_tokens,
    output logic [CNT_W-1:0]      prefill_count,
    output logic [CNT_W-1:0]      decode_count
);

    cfg_t                  cfg_reg;
    batch_t                batch_reg;
    batch_t                batch_next;
    decide_t               decide;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    decide_t               res_decide_reg;
    batch_t                res_batch_reg;
    logic [TOKEN_BITS-1:0] res_tag_reg;
    logic                  accept;
    logic                  cfg_write;

    // Configuration writes
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.batch_limit  <= BATCH_LIMIT_RST;
            cfg_reg.token_limit  <= TOKEN_LIMIT_RST;
            cfg_reg.split_enable <= 1'b0;
            cfg_reg.chunk_size   <= CHUNK_SIZE_RST;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_BATCH_LIMIT:  cfg_reg.batch_limit  <= pwdata[CNT_W-1:0];
                REG_TOKEN_LIMIT:  cfg_reg.token_limit  <= pwdata[TOKEN_BITS-1:0];
                REG_SPLIT_ENABLE: cfg_reg.split_enable <= pwdata[0];
                REG_CHUNK_SIZE:   cfg_reg.chunk_size   <= pwdata[TOKEN_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[3:2])
            REG_BATCH_LIMIT:  prdata = DATA_W'(cfg_reg.batch_limit);
            REG_TOKEN_LIMIT:  prdata = DATA_W'(cfg_reg.token_limit);
            REG_SPLIT_ENABLE: prdata = DATA_W'(cfg_reg.split_enable);
            REG_CHUNK_SIZE:   prdata = DATA_W'(cfg_reg.chunk_size);
            default:          prdata = '0;
        endcase
    end

    // Handshake: take an item whenever the result register is free or draining
    assign in_ready       = !out_valid_reg || out_ready;
    assign accept         = in_valid && in_ready;
    assign out_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    tbba_admit u_admit
    (
        .cfg           (cfg_reg),
        .batch         (batch_reg),
        .action        (action),
        .from_pending  (from_pending),
        .phase         (phase),
        .prompt_tokens (prompt_tokens),
        .done_tokens   (done_tokens),
        .batch_next    (batch_next),
        .decide        (decide)
    );

    // Batch state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                batch_reg <= batch_next;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_decide_reg <= decide;
            res_batch_reg  <= batch_next;
            res_tag_reg    <= request_tag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tag_out        = res_tag_reg;
    assign admitted       = res_decide_reg.admitted;
    assign requeue        = res_decide_reg.requeue;
    assign new_phase      = res_decide_reg.new_phase;
    assign pending_closed = res_batch_reg.closed;
    assign batch_count    = res_batch_reg.count;
    assign batch_tokens   = res_batch_reg.tokens;
    assign prefill_count  = res_batch_reg.prefill;
    assign decode_count   = res_batch_reg.decode;

endmodule
